// ===== rtl/core/wls_pkg.sv =====
// wls_pkg: widths, register map, step codes and microcode ROM for the
// rolling-window latency statistics block. No dependencies.

package wls_pkg;

   localparam int SAMPLE_W         = 20;
   localparam int RATE_W           = 27;
   localparam int FILL_W           = 7;
   localparam int LEN_W            = 7;
   localparam int APB_ADDR_W       = 3;
   localparam int APB_DATA_W       = 32;
   localparam int WINDOW_DEPTH_DEF = 32;

   localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = 7'd30;
   localparam logic [RATE_W-1:0] CENTI_FPS_US   = 27'd100000000;

   // word select, paddr[2]
   localparam logic REG_WINDOW_LEN = 1'b0;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_EVICT,
      STEP_INSERT,
      STEP_MEAN_LOAD,
      STEP_MEAN_DIV,
      STEP_MEAN_SAVE,
      STEP_RATE_DIV,
      STEP_SCAN,
      STEP_SCAN_TAIL,
      STEP_OUTPUT
   } step_type;

   typedef enum logic [2:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_DIV,
      HOLD_SCAN,
      HOLD_OUT_BUSY
   } hold_type;

   typedef struct packed {
      logic     take_req;    // open the input, latch the beat
      logic     rd_oldest;   // read the slot about to be evicted
      logic     evict;       // drop oldest from sum and count
      logic     insert;      // write sample, bump slot, count, sum
      logic     mean_load;   // divider <- sum / count
      logic     div_step;    // one radix-2 divider step
      logic     mean_save;   // keep mean, divider <- 1e8 / mean, start scan
      logic     scan_rd;     // read next window entry for the max
      logic     out_load;    // load the result register
      hold_type hold;        // stay on this step while the condition holds
      step_type next;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w      = '0;
      w.hold = HOLD_NONE;
      w.next = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.take_req  = 1'b1;
            w.rd_oldest = 1'b1;
            w.hold      = HOLD_NO_REQ;
            w.next      = STEP_EVICT;
         end
         STEP_EVICT: begin
            w.evict = 1'b1;
            w.next  = STEP_INSERT;
         end
         STEP_INSERT: begin
            w.insert = 1'b1;
            w.next   = STEP_MEAN_LOAD;
         end
         STEP_MEAN_LOAD: begin
            w.mean_load = 1'b1;
            w.next      = STEP_MEAN_DIV;
         end
         STEP_MEAN_DIV: begin
            w.div_step = 1'b1;
            w.hold     = HOLD_DIV;
            w.next     = STEP_MEAN_SAVE;
         end
         STEP_MEAN_SAVE: begin
            w.mean_save = 1'b1;
            w.next      = STEP_RATE_DIV;
         end
         STEP_RATE_DIV: begin
            w.div_step = 1'b1;
            w.hold     = HOLD_DIV;
            w.next     = STEP_SCAN;
         end
         STEP_SCAN: begin
            w.scan_rd = 1'b1;
            w.hold    = HOLD_SCAN;
            w.next    = STEP_SCAN_TAIL;
         end
         STEP_SCAN_TAIL: begin
            w.next = STEP_OUTPUT;
         end
         STEP_OUTPUT: begin
            w.out_load = 1'b1;
            w.hold     = HOLD_OUT_BUSY;
            w.next     = STEP_IDLE;
         end
         default: begin
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/window_latency_statistics.sv =====
// window_latency_statistics: top level, microcoded sequencer and datapath.
// Depends on wls_pkg (widths, step codes, microcode ROM).
//
// Each accepted beat adds one 20-bit latency sample to a rolling window of
// the last window_len samples (clamped to 1..WINDOW_DEPTH; a shrunk window
// drops one old sample per new one) and returns one result beat with the
// integer mean, the window maximum, 100000000/mean (0 for a zero mean) and
// the fill count. One item is in flight at a time; from accept to result the
// block runs two radix-2 divisions on one shared divider, whose width is 27
// at the default depth, and a scan of the sample memory at one read per
// cycle. The next beat is taken as soon as the result is in the output
// register, while it waits to be taken. window_len sits at byte address 0
// of the APB port.

module window_latency_statistics #(
   parameter int WINDOW_DEPTH = wls_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wls_pkg::SAMPLE_W-1:0]      req_sample_us,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wls_pkg::SAMPLE_W-1:0]      rsp_mean_us,
   output logic [wls_pkg::SAMPLE_W-1:0]      rsp_peak_us,
   output logic [wls_pkg::RATE_W-1:0]        rsp_rate_centi_fps,
   output logic [wls_pkg::FILL_W-1:0]        rsp_filled,
   // configuration
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wls_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [wls_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [wls_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int SAMPLE_W = wls_pkg::SAMPLE_W;
   localparam int RATE_W   = wls_pkg::RATE_W;
   localparam int LEN_W    = wls_pkg::LEN_W;
   localparam int ADDR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int OLD_W    = CNT_W + 1;
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int DIV_W    = (SUM_W > RATE_W) ? SUM_W : RATE_W;
   localparam int REM_W    = SAMPLE_W + 1;
   localparam int DCNT_W   = $clog2(DIV_W + 1);

   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);

   // ---------------------------------------------------------------- config
   logic [LEN_W-1:0] window_len_ff, window_len_in;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr[2] == wls_pkg::REG_WINDOW_LEN) ?
                   wls_pkg::APB_DATA_W'(window_len_ff) : '0;

   always_comb begin
      window_len_in = window_len_ff;
      if (csr_wr && paddr[2] == wls_pkg::REG_WINDOW_LEN) begin
         window_len_in = pwdata[LEN_W-1:0];
      end
   end

   // ------------------------------------------------------------- sequencer
   wls_pkg::step_type  step_ff, step_in;
   wls_pkg::ucode_type cw;
   logic               hold_now;
   logic               req_accept;
   logic               rsp_accept;

   logic [DCNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign cw         = wls_pkg::ucode_rom(step_ff);
   assign req_stall  = ~cw.take_req;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      unique case (cw.hold)
         wls_pkg::HOLD_NO_REQ:   hold_now = ~req_accept;
         wls_pkg::HOLD_DIV:      hold_now = (div_cnt_ff != DCNT_W'(1));
         wls_pkg::HOLD_SCAN:     hold_now = (scan_left_ff != CNT_W'(1));
         wls_pkg::HOLD_OUT_BUSY: hold_now = rsp_valid_ff & rsp_stall;
         default:                hold_now = 1'b0;
      endcase
      step_in = hold_now ? step_ff : cw.next;
   end

   // -------------------------------------------------------------- datapath
   logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] rd_ff;
   logic                rd_live_ff, rd_live_in;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_en;

   logic [SAMPLE_W-1:0] sample_ff;
   logic                evict_ff;
   logic [ADDR_W-1:0]   wslot_ff, wslot_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADDR_W-1:0]   scan_addr_ff;

   logic [LEN_W-1:0]    len_eff;
   logic                evict_now;
   logic [OLD_W-1:0]    old_raw;
   logic [ADDR_W-1:0]   oldest_addr;
   logic [ADDR_W-1:0]   wslot_prev;
   logic [ADDR_W-1:0]   scan_prev;

   logic [DIV_W-1:0]    div_quo_ff;
   logic [REM_W-1:0]    div_rem_ff;
   logic [SAMPLE_W-1:0] div_den_ff;
   logic [REM_W-1:0]    rem_shift;
   logic                quo_bit;
   logic [REM_W-1:0]    rem_next;

   logic [SAMPLE_W-1:0] mean_ff;
   logic [SAMPLE_W-1:0] peak_ff;

   logic [SAMPLE_W-1:0] out_mean_ff;
   logic [SAMPLE_W-1:0] out_peak_ff;
   logic [RATE_W-1:0]   out_rate_ff;
   logic [CNT_W-1:0]    out_fill_ff;

   // window length clamped to 1..WINDOW_DEPTH
   always_comb begin
      len_eff = window_len_ff;
      if (window_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (window_len_ff > LEN_W'(WINDOW_DEPTH)) begin
         len_eff = LEN_W'(WINDOW_DEPTH);
      end
   end

   assign evict_now = (LEN_W'(count_ff) >= len_eff);

   // oldest = (wslot - count) mod depth, with count <= depth
   always_comb begin
      old_raw = OLD_W'(wslot_ff) + OLD_W'(WINDOW_DEPTH) - OLD_W'(count_ff);
      if (old_raw >= OLD_W'(WINDOW_DEPTH)) begin
         old_raw = old_raw - OLD_W'(WINDOW_DEPTH);
      end
      oldest_addr = old_raw[ADDR_W-1:0];
   end

   assign wslot_prev = (wslot_ff == '0) ? LAST_SLOT : wslot_ff - ADDR_W'(1);
   assign scan_prev  = (scan_addr_ff == '0) ? LAST_SLOT : scan_addr_ff - ADDR_W'(1);

   assign rd_en   = cw.rd_oldest | cw.scan_rd;
   assign rd_addr = cw.scan_rd ? scan_addr_ff : oldest_addr;

   always_comb begin
      wslot_in = wslot_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cw.evict && evict_ff) begin
         count_in = count_ff - CNT_W'(1);
         sum_in   = sum_ff - SUM_W'(rd_ff);
      end
      if (cw.insert) begin
         wslot_in = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + ADDR_W'(1);
         count_in = count_ff + CNT_W'(1);
         sum_in   = sum_ff + SUM_W'(sample_ff);
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_shift = {div_rem_ff[SAMPLE_W-1:0], div_quo_ff[DIV_W-1]};
   assign quo_bit   = (rem_shift >= {1'b0, div_den_ff});
   assign rem_next  = quo_bit ? rem_shift - {1'b0, div_den_ff} : rem_shift;

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (cw.mean_load || cw.mean_save) begin
         div_cnt_in = DCNT_W'(DIV_W);
      end else if (cw.div_step) begin
         div_cnt_in = div_cnt_ff - DCNT_W'(1);
      end

      scan_left_in = scan_left_ff;
      if (cw.mean_save) begin
         scan_left_in = count_ff;
      end else if (cw.scan_rd) begin
         scan_left_in = scan_left_ff - CNT_W'(1);
      end

      rd_live_in = cw.scan_rd;

      rsp_valid_in = rsp_valid_ff;
      if (cw.out_load && !hold_now) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= wls_pkg::STEP_IDLE;
         window_len_ff <= wls_pkg::WINDOW_LEN_RST;
         wslot_ff      <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         div_cnt_ff    <= '0;
         scan_left_ff  <= '0;
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         window_len_ff <= window_len_in;
         wslot_ff      <= wslot_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         div_cnt_ff    <= div_cnt_in;
         scan_left_ff  <= scan_left_in;
         rd_live_ff    <= rd_live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // sample memory, registered read
   always_ff @(posedge clock) begin
      if (cw.insert) begin
         ring_mem[wslot_ff] <= sample_ff;
      end
      if (rd_en) begin
         rd_ff <= ring_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample_us;
         evict_ff  <= evict_now;
      end

      if (cw.mean_load) begin
         div_quo_ff <= DIV_W'(sum_ff);
         div_rem_ff <= '0;
         div_den_ff <= SAMPLE_W'(count_ff);
      end else if (cw.mean_save) begin
         div_quo_ff <= DIV_W'(wls_pkg::CENTI_FPS_US);
         div_rem_ff <= '0;
         div_den_ff <= div_quo_ff[SAMPLE_W-1:0];
      end else if (cw.div_step) begin
         div_quo_ff <= {div_quo_ff[DIV_W-2:0], quo_bit};
         div_rem_ff <= rem_next;
      end

      if (cw.mean_save) begin
         mean_ff      <= div_quo_ff[SAMPLE_W-1:0];
         scan_addr_ff <= wslot_prev;
         peak_ff      <= '0;
      end else begin
         if (cw.scan_rd) begin
            scan_addr_ff <= scan_prev;
         end
         // compare acts on the read data in the cycle after the read
         if (rd_live_ff && rd_ff > peak_ff) begin
            peak_ff <= rd_ff;
         end
      end

      if (cw.out_load && !hold_now) begin
         out_mean_ff <= mean_ff;
         out_peak_ff <= peak_ff;
         out_rate_ff <= (mean_ff == '0) ? '0 : div_quo_ff[RATE_W-1:0];
         out_fill_ff <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_us        = out_mean_ff;
   assign rsp_peak_us        = out_peak_ff;
   assign rsp_rate_centi_fps = out_rate_ff;
   assign rsp_filled         = wls_pkg::FILL_W'(out_fill_ff);

endmodule
